/* src/mts_pkg.sv */
// Shared types, constants and the step control table of the mode transition sequencer.
package mts_pkg;

    localparam int STEP_W    = 4;
    localparam int ELAPSED_W = 16;
    localparam int DUR_W     = 12;
    localparam int STEPS_W   = 8;
    localparam int ANGLE_W   = 8;
    localparam int PROD_W    = 15;
    localparam int QUO_W     = 7;
    localparam int CNT_W     = 4;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_ESTOP = 2'd2;

    localparam logic [1:0] MODE_AIR    = 2'd0;
    localparam logic [1:0] MODE_GROUND = 2'd1;
    localparam logic [1:0] MODE_SEA    = 2'd2;

    localparam logic [1:0] DRIVE_STOP    = 2'd0;
    localparam logic [1:0] DRIVE_EXTEND  = 2'd1;
    localparam logic [1:0] DRIVE_RETRACT = 2'd2;

    localparam logic [ANGLE_W-1:0] ARM_UP      = 8'd130;
    localparam logic [ANGLE_W-1:0] ARM_DOWN    = 8'd20;
    localparam logic [ANGLE_W-1:0] DIR_FLIGHT  = 8'd45;
    localparam logic [ANGLE_W-1:0] DIR_SURFACE = 8'd155;
    localparam logic [QUO_W-1:0]   RAMP_SPAN   = 7'd110;

    localparam logic [DUR_W-1:0]   EXTEND_RST = 12'd2000;
    localparam logic [DUR_W-1:0]   RETRACT_RST = 12'd2000;
    localparam logic [DUR_W-1:0]   GEAR_RST   = 12'd2000;
    localparam logic [STEPS_W-1:0] STEPS_RST  = 8'd100;

    localparam logic [STEP_W-1:0] STEP_REST       = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FL_EXTEND  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_FL_ARM     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_FL_DIR     = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FL_RETRACT = 4'd4;
    localparam logic [STEP_W-1:0] STEP_FL_DONE    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LF_RETRACT = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LF_GEAR    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LF_ARM     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LF_DIR     = 4'd9;
    localparam logic [STEP_W-1:0] STEP_LF_EXTEND  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_LF_DONE    = 4'd11;
    localparam logic [STEP_W-1:0] STEP_FW_ARM     = 4'd12;
    localparam logic [STEP_W-1:0] STEP_FW_DIR     = 4'd13;
    localparam logic [STEP_W-1:0] STEP_FW_DONE    = 4'd14;

    typedef enum logic [2:0] {
        KIND_IDLE,
        KIND_F2L,
        KIND_L2F,
        KIND_F2W,
        KIND_W2F
    } t_kind;

    typedef enum logic [1:0] {
        REG_EXTEND,
        REG_RETRACT,
        REG_GEAR,
        REG_RAMP
    } t_reg_idx;

    typedef enum logic [1:0] {
        UOP_ABORT,
        UOP_TIMED,
        UOP_RAMP,
        UOP_FINISH
    } t_uop_op;

    typedef enum logic [1:0] {
        DUR_EXTEND,
        DUR_RETRACT,
        DUR_GEAR
    } t_dur_sel;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_uop_op           op;
        logic              set_drive;
        logic [1:0]        drive;
        t_dur_sel          dur;
        logic              servo_is_dir;
        logic              by_kind;
        logic              back;
        logic [STEP_W-1:0] next;
        logic              clr_timer;
        logic              clr_ramp;
        logic [1:0]        fin_mode;
    } t_uop;

    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '0;
        case (step)
            STEP_FL_EXTEND: begin
                u.op = UOP_TIMED; u.drive = DRIVE_EXTEND; u.dur = DUR_EXTEND;
                u.next = STEP_FL_ARM; u.clr_timer = 1'b1; u.clr_ramp = 1'b1;
            end
            STEP_FL_ARM: begin
                u.op = UOP_RAMP; u.next = STEP_FL_DIR;
                u.clr_timer = 1'b1; u.clr_ramp = 1'b1;
            end
            STEP_FL_DIR: begin
                u.op = UOP_RAMP; u.servo_is_dir = 1'b1; u.next = STEP_FL_RETRACT;
                u.clr_timer = 1'b1;
            end
            STEP_FL_RETRACT: begin
                u.op = UOP_TIMED; u.drive = DRIVE_RETRACT; u.dur = DUR_RETRACT;
                u.next = STEP_FL_DONE;
            end
            STEP_FL_DONE: begin
                u.op = UOP_FINISH; u.set_drive = 1'b1; u.fin_mode = MODE_GROUND;
            end
            STEP_LF_RETRACT: begin
                u.op = UOP_TIMED; u.drive = DRIVE_RETRACT; u.dur = DUR_RETRACT;
                u.next = STEP_LF_GEAR; u.clr_timer = 1'b1;
            end
            STEP_LF_GEAR: begin
                u.op = UOP_TIMED; u.drive = DRIVE_STOP; u.dur = DUR_GEAR;
                u.next = STEP_LF_ARM; u.clr_timer = 1'b1; u.clr_ramp = 1'b1;
            end
            STEP_LF_ARM: begin
                u.op = UOP_RAMP; u.back = 1'b1; u.next = STEP_LF_DIR;
                u.clr_timer = 1'b1; u.clr_ramp = 1'b1;
            end
            STEP_LF_DIR: begin
                u.op = UOP_RAMP; u.servo_is_dir = 1'b1; u.back = 1'b1;
                u.next = STEP_LF_EXTEND; u.clr_timer = 1'b1;
            end
            STEP_LF_EXTEND: begin
                u.op = UOP_TIMED; u.drive = DRIVE_EXTEND; u.dur = DUR_EXTEND;
                u.next = STEP_LF_DONE;
            end
            STEP_LF_DONE: begin
                u.op = UOP_FINISH; u.set_drive = 1'b1; u.fin_mode = MODE_AIR;
            end
            STEP_FW_ARM: begin
                u.op = UOP_RAMP; u.by_kind = 1'b1; u.next = STEP_FW_DIR;
                u.clr_ramp = 1'b1;
            end
            STEP_FW_DIR: begin
                u.op = UOP_RAMP; u.servo_is_dir = 1'b1; u.by_kind = 1'b1;
                u.next = STEP_FW_DONE;
            end
            STEP_FW_DONE: begin
                u.op = UOP_FINISH; u.by_kind = 1'b1;
            end
            default: begin
                u.op = UOP_ABORT;
            end
        endcase
        return u;
    endfunction

endpackage

/* src/mode_transition_sequencer.sv */
// Top level of the mode transition sequencer: step table, datapath, handshakes and registers.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_opcode, i_target_mode, i_tick_ms
//   result    out        o_out_valid / i_out_stall  o_mode_now .. o_rejected
//   config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// A start, a stop or a tick outside a ramp passes through the execute and output states.
// A ramp tick also waits in the divide state between them for the bit-serial divider.
// Only one beat is in work at a time; the next is taken once the result is registered.
// A stalled result holds while the next beat is accepted and worked on.
// Synchronous reset restores the default timings, flight mode and the resting angles.
module mode_transition_sequencer
    import mts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_target_mode,
    input  logic [7:0]         i_tick_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_mode_now,
    output logic [STEP_W-1:0]  o_step_code,
    output logic [1:0]         o_pushrod_drive,
    output logic [ANGLE_W-1:0] o_arm_angle,
    output logic [ANGLE_W-1:0] o_direction_angle,
    output logic               o_busy_res,
    output logic               o_rejected,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_state               r_state, n_state;
    logic [1:0]           r_mode, n_mode;
    t_kind                r_kind, n_kind;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [STEPS_W-1:0]   r_progress, n_progress;
    logic [1:0]           r_drive, n_drive;
    logic [ANGLE_W-1:0]   r_arm, n_arm;
    logic [ANGLE_W-1:0]   r_dir, n_dir;
    logic                 r_rej, n_rej;
    logic                 r_out_valid, n_out_valid;

    logic [DUR_W-1:0]     r_extend, r_retract, r_gear;
    logic [STEPS_W-1:0]   r_ramp_steps;

    logic [1:0]           r_op, r_target;
    logic [7:0]           r_tick;

    logic [1:0]           r_o_mode, r_o_drive;
    logic [STEP_W-1:0]    r_o_step;
    logic [ANGLE_W-1:0]   r_o_arm, r_o_dir;
    logic                 r_o_busy, r_o_rej;

    t_uop                 uop;
    logic                 back;
    logic                 ramp_sub;
    logic [ANGLE_W-1:0]   ramp_from;
    logic [ANGLE_W-1:0]   angle_new;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic [ELAPSED_W-1:0] elapsed_sat;
    logic [DUR_W-1:0]     dur;
    logic                 timed_done;
    logic [STEPS_W-1:0]   prog_inc;
    logic                 ramp_active;
    logic                 ramp_done_after;
    logic [PROD_W-1:0]    product;
    logic [1:0]           fin_mode;
    logic                 accept;
    logic                 div_go;
    logic                 div_done;
    logic [QUO_W-1:0]     quotient;
    logic                 out_load;
    logic                 cfg_we;

    assign accept      = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    assign uop         = uop_rom(r_step);
    assign back        = uop.by_kind ? (r_kind == KIND_W2F) : uop.back;
    assign ramp_sub    = uop.servo_is_dir ? back : !back;
    assign elapsed_sum = {1'b0, r_elapsed} + (ELAPSED_W + 1)'(r_tick);
    assign elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
    assign timed_done  = (elapsed_sat >= ELAPSED_W'(dur));
    assign prog_inc    = r_progress + 1'b1;
    assign ramp_active = (r_progress < r_ramp_steps);
    assign ramp_done_after = (prog_inc >= r_ramp_steps);
    assign product     = PROD_W'(r_progress) * PROD_W'(RAMP_SPAN);
    assign angle_new   = ramp_sub ? (ramp_from - ANGLE_W'(quotient))
                                  : (ramp_from + ANGLE_W'(quotient));
    assign fin_mode    = uop.by_kind ? ((r_kind == KIND_F2W) ? MODE_SEA : MODE_AIR)
                                     : uop.fin_mode;
    assign div_go      = (r_state == ST_EXEC) && (r_op == OP_TICK) && (r_kind != KIND_IDLE)
                         && (uop.op == UOP_RAMP) && ramp_active;

    always_comb begin
        case ({uop.servo_is_dir, back})
            2'b00:   ramp_from = ARM_UP;
            2'b01:   ramp_from = ARM_DOWN;
            2'b10:   ramp_from = DIR_FLIGHT;
            default: ramp_from = DIR_SURFACE;
        endcase
    end

    always_comb begin
        case (uop.dur)
            DUR_EXTEND:  dur = r_extend;
            DUR_RETRACT: dur = r_retract;
            default:     dur = r_gear;
        endcase
    end

    mts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (product),
        .i_divisor  (r_ramp_steps),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC: n_state = div_go ? ST_DIV : ST_OUT;
            ST_DIV:  if (div_done) n_state = ST_OUT;
            ST_OUT:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_mode      = r_mode;
        n_kind      = r_kind;
        n_step      = r_step;
        n_elapsed   = r_elapsed;
        n_progress  = r_progress;
        n_drive     = r_drive;
        n_arm       = r_arm;
        n_dir       = r_dir;
        n_rej       = r_rej;
        n_out_valid = r_out_valid;
        if (o_out_valid && !i_out_stall) n_out_valid = 1'b0;
        case (r_state)
            ST_EXEC: begin
                n_rej = 1'b0;
                case (r_op)
                    OP_TICK: begin
                        if (r_kind != KIND_IDLE) begin
                            n_elapsed = elapsed_sat;
                            case (uop.op)
                                UOP_TIMED: begin
                                    n_drive = uop.drive;
                                    if (timed_done) begin
                                        n_step = uop.next;
                                        if (uop.clr_timer) n_elapsed = '0;
                                        if (uop.clr_ramp) n_progress = '0;
                                    end
                                end
                                UOP_RAMP: begin
                                    if (!ramp_active) begin
                                        n_step = uop.next;
                                        if (uop.clr_timer) n_elapsed = '0;
                                        if (uop.clr_ramp) n_progress = '0;
                                    end
                                end
                                UOP_FINISH: begin
                                    n_mode = fin_mode;
                                    n_kind = KIND_IDLE;
                                    n_step = STEP_REST;
                                    if (uop.set_drive) n_drive = DRIVE_STOP;
                                end
                                default: begin
                                    n_kind = KIND_IDLE;
                                    n_step = STEP_REST;
                                end
                            endcase
                        end
                    end
                    OP_START: begin
                        if (r_kind != KIND_IDLE) begin
                            n_rej = 1'b1;
                        end else begin
                            n_elapsed  = '0;
                            n_progress = '0;
                            if (r_mode == MODE_AIR && r_target == MODE_GROUND) begin
                                n_kind = KIND_F2L;
                                n_step = STEP_FL_EXTEND;
                            end else if (r_mode == MODE_GROUND && r_target == MODE_AIR) begin
                                n_kind = KIND_L2F;
                                n_step = STEP_LF_RETRACT;
                            end else if (r_mode == MODE_AIR && r_target == MODE_SEA) begin
                                n_kind = KIND_F2W;
                                n_step = STEP_FW_ARM;
                            end else if (r_mode == MODE_SEA && r_target == MODE_AIR) begin
                                n_kind = KIND_W2F;
                                n_step = STEP_FW_ARM;
                            end else begin
                                n_rej = 1'b1;
                            end
                        end
                    end
                    OP_ESTOP: begin
                        n_kind  = KIND_IDLE;
                        n_step  = STEP_REST;
                        n_drive = DRIVE_STOP;
                    end
                    default: begin
                    end
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    if (uop.servo_is_dir) n_dir = angle_new;
                    else n_arm = angle_new;
                    n_progress = prog_inc;
                    if (ramp_done_after) begin
                        n_step = uop.next;
                        if (uop.clr_timer) n_elapsed = '0;
                        if (uop.clr_ramp) n_progress = '0;
                    end
                end
            end
            ST_OUT: begin
                if (out_load) n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_AIR;
            r_kind      <= KIND_IDLE;
            r_step      <= STEP_REST;
            r_elapsed   <= '0;
            r_progress  <= '0;
            r_drive     <= DRIVE_STOP;
            r_arm       <= ARM_UP;
            r_dir       <= DIR_FLIGHT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_kind      <= n_kind;
            r_step      <= n_step;
            r_elapsed   <= n_elapsed;
            r_progress  <= n_progress;
            r_drive     <= n_drive;
            r_arm       <= n_arm;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rej <= n_rej;
        if (accept) begin
            r_op     <= i_opcode;
            r_target <= i_target_mode;
            r_tick   <= i_tick_ms;
        end
        if (out_load) begin
            r_o_mode  <= r_mode;
            r_o_step  <= r_step;
            r_o_drive <= r_drive;
            r_o_arm   <= r_arm;
            r_o_dir   <= r_dir;
            r_o_busy  <= (r_kind != KIND_IDLE);
            r_o_rej   <= r_rej;
        end
    end

    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extend     <= EXTEND_RST;
            r_retract    <= RETRACT_RST;
            r_gear       <= GEAR_RST;
            r_ramp_steps <= STEPS_RST;
        end else if (cfg_we) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_EXTEND:  r_extend     <= pwdata[DUR_W-1:0];
                REG_RETRACT: r_retract    <= pwdata[DUR_W-1:0];
                REG_GEAR:    r_gear       <= pwdata[DUR_W-1:0];
                default:     r_ramp_steps <= pwdata[STEPS_W-1:0];
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_EXTEND:  prdata = DATA_W'(r_extend);
            REG_RETRACT: prdata = DATA_W'(r_retract);
            REG_GEAR:    prdata = DATA_W'(r_gear);
            default:     prdata = DATA_W'(r_ramp_steps);
        endcase
    end

    assign pready            = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_mode_now        = r_o_mode;
    assign o_step_code       = r_o_step;
    assign o_pushrod_drive   = r_o_drive;
    assign o_arm_angle       = r_o_arm;
    assign o_direction_angle = r_o_dir;
    assign o_busy_res        = r_o_busy;
    assign o_rejected        = r_o_rej;

endmodule

/* src/mts_div.sv */
// Restoring divider that maps ramp progress onto an angle offset, one quotient bit per cycle.
module mts_div
    import mts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PROD_W-1:0]  i_dividend,
    input  logic [STEPS_W-1:0] i_divisor,
    output logic               o_done,
    output logic [QUO_W-1:0]   o_quotient
);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_quo;
    logic [STEPS_W-1:0] r_rem;
    logic [STEPS_W-1:0] r_div;
    logic [STEPS_W:0]   trial;
    logic [STEPS_W:0]   diff;
    logic               ge;
    logic [STEPS_W-1:0] n_rem;

    assign trial = {r_rem, r_quo[PROD_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});
    assign n_rem = ge ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PROD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[QUO_W-1:0];

endmodule

/* src/mts_checker.sv */
// Port-level assertions for the mode transition sequencer and their binding to the top level.
module mts_checker
    import mts_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [STEP_W-1:0]  o_step_code,
    input logic [ANGLE_W-1:0] o_arm_angle,
    input logic [ANGLE_W-1:0] o_direction_angle,
    input logic               o_busy_res
);

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("A second beat was taken while one was in work.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_step_code)
            && $stable(o_arm_angle) && $stable(o_direction_angle))
        else $error("A stalled result beat changed.");

    a_busy_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_busy_res == (o_step_code != STEP_REST)))
        else $error("Busy flag disagrees with the step code.");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_arm_angle >= ARM_DOWN && o_arm_angle <= ARM_UP
            && o_direction_angle >= DIR_FLIGHT && o_direction_angle <= DIR_SURFACE)
        else $error("A servo angle left its ramp range.");

endmodule

bind mode_transition_sequencer mts_checker u_mts_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_step_code       (o_step_code),
    .o_arm_angle       (o_arm_angle),
    .o_direction_angle (o_direction_angle),
    .o_busy_res        (o_busy_res)
);

/* tb/mode_sequence_checker.sv */
`timescale 1ns / 1ps
// Channel monitor, mode sequence predictor and result comparator for the mode transition sequencer.
module mode_sequence_checker
    import mts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_target_mode,
    input  logic [7:0]         i_tick_ms,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_mode_now,
    input  logic [STEP_W-1:0]  i_step_code,
    input  logic [1:0]         i_pushrod_drive,
    input  logic [ANGLE_W-1:0] i_arm_angle,
    input  logic [ANGLE_W-1:0] i_direction_angle,
    input  logic               i_busy_res,
    input  logic               i_rejected,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output int                 o_mismatches,
    output int                 o_pending
);

    typedef struct packed {
        logic [1:0]         mode;
        logic [STEP_W-1:0]  step;
        logic [1:0]         drive;
        logic [ANGLE_W-1:0] arm;
        logic [ANGLE_W-1:0] dir;
        logic               busy;
        logic               rejected;
    } t_status;

    t_status status_q[$];
    int      mismatch_cnt = 0;
    int      result_idx = 0;

    logic [DUR_W-1:0]     extend_cfg;
    logic [DUR_W-1:0]     retract_cfg;
    logic [DUR_W-1:0]     gear_cfg;
    logic [STEPS_W-1:0]   steps_cfg;

    logic [1:0]           mode_r;
    t_kind                kind_r;
    logic [STEP_W-1:0]    step_r;
    logic [ELAPSED_W-1:0] elapsed_r;
    logic [STEPS_W-1:0]   progress_r;
    logic [1:0]           drive_r;
    logic [ANGLE_W-1:0]   arm_r;
    logic [ANGLE_W-1:0]   dir_r;

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      result_idx, name, got, want));
        end
    endtask

    task automatic reset_sequencer();
        extend_cfg  = EXTEND_RST;
        retract_cfg = RETRACT_RST;
        gear_cfg    = GEAR_RST;
        steps_cfg   = STEPS_RST;
        mode_r      = MODE_AIR;
        kind_r      = KIND_IDLE;
        step_r      = STEP_REST;
        elapsed_r   = '0;
        progress_r  = '0;
        drive_r     = DRIVE_STOP;
        arm_r       = ARM_UP;
        dir_r       = DIR_FLIGHT;
    endtask

    // One ramp tick writes the truncated interpolation and then advances the progress count.
    task automatic ramp_servo(inout logic [ANGLE_W-1:0] angle, input int from, input int to);
        if (progress_r < steps_cfg) begin
            angle = ANGLE_W'(from + (int'(progress_r) * (to - from)) / int'(steps_cfg));
            progress_r = progress_r + 1'b1;
        end
    endtask

    task automatic enter_step(input logic [STEP_W-1:0] s, input bit clr_timer, input bit clr_ramp);
        step_r = s;
        if (clr_timer) elapsed_r = '0;
        if (clr_ramp) progress_r = '0;
    endtask

    task automatic finish_sequence(input logic [1:0] mode);
        mode_r = mode;
        kind_r = KIND_IDLE;
        step_r = STEP_REST;
    endtask

    task automatic run_sequence_step();
        bit to_water;
        bit ramp_done;
        to_water = (kind_r == KIND_F2W);
        case (step_r)
            STEP_FL_EXTEND: begin
                drive_r = DRIVE_EXTEND;
                if (elapsed_r >= extend_cfg) enter_step(STEP_FL_ARM, 1'b1, 1'b1);
            end
            STEP_FL_ARM: begin
                ramp_servo(arm_r, ARM_UP, ARM_DOWN);
                if (progress_r >= steps_cfg) enter_step(STEP_FL_DIR, 1'b1, 1'b1);
            end
            STEP_FL_DIR: begin
                ramp_servo(dir_r, DIR_FLIGHT, DIR_SURFACE);
                if (progress_r >= steps_cfg) enter_step(STEP_FL_RETRACT, 1'b1, 1'b0);
            end
            STEP_FL_RETRACT: begin
                drive_r = DRIVE_RETRACT;
                if (elapsed_r >= retract_cfg) step_r = STEP_FL_DONE;
            end
            STEP_FL_DONE: begin
                finish_sequence(MODE_GROUND);
                drive_r = DRIVE_STOP;
            end
            STEP_LF_RETRACT: begin
                drive_r = DRIVE_RETRACT;
                if (elapsed_r >= retract_cfg) enter_step(STEP_LF_GEAR, 1'b1, 1'b0);
            end
            STEP_LF_GEAR: begin
                drive_r = DRIVE_STOP;
                if (elapsed_r >= gear_cfg) enter_step(STEP_LF_ARM, 1'b1, 1'b1);
            end
            STEP_LF_ARM: begin
                ramp_servo(arm_r, ARM_DOWN, ARM_UP);
                if (progress_r >= steps_cfg) enter_step(STEP_LF_DIR, 1'b1, 1'b1);
            end
            STEP_LF_DIR: begin
                ramp_servo(dir_r, DIR_SURFACE, DIR_FLIGHT);
                if (progress_r >= steps_cfg) enter_step(STEP_LF_EXTEND, 1'b1, 1'b0);
            end
            STEP_LF_EXTEND: begin
                drive_r = DRIVE_EXTEND;
                if (elapsed_r >= extend_cfg) step_r = STEP_LF_DONE;
            end
            STEP_LF_DONE: begin
                finish_sequence(MODE_AIR);
                drive_r = DRIVE_STOP;
            end
            STEP_FW_ARM: begin
                if (to_water) ramp_servo(arm_r, ARM_UP, ARM_DOWN);
                else ramp_servo(arm_r, ARM_DOWN, ARM_UP);
                if (progress_r >= steps_cfg) enter_step(STEP_FW_DIR, 1'b0, 1'b1);
            end
            STEP_FW_DIR: begin
                if (to_water) ramp_servo(dir_r, DIR_FLIGHT, DIR_SURFACE);
                else ramp_servo(dir_r, DIR_SURFACE, DIR_FLIGHT);
                if (progress_r >= steps_cfg) step_r = STEP_FW_DONE;
            end
            STEP_FW_DONE: begin
                finish_sequence(to_water ? MODE_SEA : MODE_AIR);
            end
            default: begin
                kind_r = KIND_IDLE;
                step_r = STEP_REST;
            end
        endcase
    endtask

    task automatic start_sequence(input logic [1:0] tgt, output bit accepted);
        accepted = 1'b0;
        if (kind_r == KIND_IDLE) begin
            elapsed_r  = '0;
            progress_r = '0;
            accepted   = 1'b1;
            if (mode_r == MODE_AIR && tgt == MODE_GROUND) begin
                kind_r = KIND_F2L;
                step_r = STEP_FL_EXTEND;
            end else if (mode_r == MODE_GROUND && tgt == MODE_AIR) begin
                kind_r = KIND_L2F;
                step_r = STEP_LF_RETRACT;
            end else if (mode_r == MODE_AIR && tgt == MODE_SEA) begin
                kind_r = KIND_F2W;
                step_r = STEP_FW_ARM;
            end else if (mode_r == MODE_SEA && tgt == MODE_AIR) begin
                kind_r = KIND_W2F;
                step_r = STEP_FW_ARM;
            end else begin
                accepted = 1'b0;
            end
        end
    endtask

    task automatic predict_status(input logic [1:0] op, input logic [1:0] tgt,
                                  input logic [7:0] ms, output t_status s);
        bit                 accepted;
        logic [ELAPSED_W:0] sum;
        s = '0;
        case (op)
            OP_TICK: begin
                if (kind_r != KIND_IDLE) begin
                    sum = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(ms);
                    elapsed_r = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
                    run_sequence_step();
                end
            end
            OP_START: begin
                start_sequence(tgt, accepted);
                s.rejected = !accepted;
            end
            OP_ESTOP: begin
                kind_r  = KIND_IDLE;
                step_r  = STEP_REST;
                drive_r = DRIVE_STOP;
            end
            default: ;
        endcase
        s.mode  = mode_r;
        s.step  = step_r;
        s.drive = drive_r;
        s.arm   = arm_r;
        s.dir   = dir_r;
        s.busy  = (kind_r != KIND_IDLE);
    endtask

    always @(posedge i_clk) begin : monitor
        t_status want;
        t_status fresh;
        if (!i_rst_n) begin
            reset_sequencer();
            status_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no beat outstanding",
                                              result_idx));
                end else begin
                    want = status_q.pop_front();
                    check_field("mode_now", i_mode_now, want.mode);
                    check_field("step_code", i_step_code, want.step);
                    check_field("pushrod_drive", i_pushrod_drive, want.drive);
                    check_field("arm_angle", i_arm_angle, want.arm);
                    check_field("direction_angle", i_direction_angle, want.dir);
                    check_field("busy_res", i_busy_res, want.busy);
                    check_field("rejected", i_rejected, want.rejected);
                end
                result_idx++;
            end
            if (i_in_valid && !i_in_stall) begin
                predict_status(i_opcode, i_target_mode, i_tick_ms, fresh);
                status_q.push_back(fresh);
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_EXTEND:  extend_cfg  = pwdata[DUR_W-1:0];
                    REG_RETRACT: retract_cfg = pwdata[DUR_W-1:0];
                    REG_GEAR:    gear_cfg    = pwdata[DUR_W-1:0];
                    REG_RAMP:    steps_cfg   = pwdata[STEPS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= status_q.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

/* tb/tb_mode_transition_sequencer.sv */
`timescale 1ns / 1ps
// Testbench top for the mode transition sequencer: clock, reset, stimulus, idling and verdict.
module tb_mode_transition_sequencer;
    import mts_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] MODE_NONE  = 2'd3;
    localparam int         NUM_PHASES = 9;
    localparam int         PHASE_BEATS = 150;
    localparam int         SETTLE_CYCLES = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         opcode = OP_TICK;
    logic [1:0]         target_mode = MODE_AIR;
    logic [7:0]         tick_ms = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         mode_now;
    logic [STEP_W-1:0]  step_code;
    logic [1:0]         pushrod_drive;
    logic [ANGLE_W-1:0] arm_angle;
    logic [ANGLE_W-1:0] direction_angle;
    logic               busy_res;
    logic               rejected;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    int                 mismatches;
    int                 pending;
    bit                 idle_on = 1'b1;

    mode_transition_sequencer u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_opcode          (opcode),
        .i_target_mode     (target_mode),
        .i_tick_ms         (tick_ms),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_mode_now        (mode_now),
        .o_step_code       (step_code),
        .o_pushrod_drive   (pushrod_drive),
        .o_arm_angle       (arm_angle),
        .o_direction_angle (direction_angle),
        .o_busy_res        (busy_res),
        .o_rejected        (rejected),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    mode_sequence_checker u_sequence_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_opcode          (opcode),
        .i_target_mode     (target_mode),
        .i_tick_ms         (tick_ms),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_mode_now        (mode_now),
        .i_step_code       (step_code),
        .i_pushrod_drive   (pushrod_drive),
        .i_arm_angle       (arm_angle),
        .i_direction_angle (direction_angle),
        .i_busy_res        (busy_res),
        .i_rejected        (rejected),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    always #4 clk = ~clk;

    initial begin : result_stall
        forever begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL mode_transition_sequencer");
        $finish;
    end

    task automatic send_beat(input logic [1:0] op, input logic [1:0] tgt, input logic [7:0] ms);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        target_mode <= tgt;
        tick_ms     <= ms;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic write_timings(input logic [DUR_W-1:0] ext, input logic [DUR_W-1:0] ret,
                                 input logic [DUR_W-1:0] gear, input logic [STEPS_W-1:0] steps);
        apb_write(REG_EXTEND, DATA_W'(ext));
        apb_write(REG_RETRACT, DATA_W'(ret));
        apb_write(REG_GEAR, DATA_W'(gear));
        apb_write(REG_RAMP, DATA_W'(steps));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // The sender holds off until every beat it has issued has produced its result.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return DUR_W'($urandom_range(1000, 4000));
            default: return DUR_W'($urandom_range(0, 1500));
        endcase
    endfunction

    function automatic logic [STEPS_W-1:0] pick_ramp_steps();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return STEPS_W'($urandom_range(50, 255));
            default: return STEPS_W'($urandom_range(2, 16));
        endcase
    endfunction

    // Mostly ticks and well-formed starts, with a little stopping and noise.
    task automatic random_beat();
        int         r;
        logic [1:0] op;
        logic [1:0] tgt;
        logic [7:0] ms;
        r   = int'($urandom_range(0, 99));
        tgt = 2'($urandom_range(0, 3));
        ms  = 8'($urandom_range(0, 255));
        if (r < 80) begin
            op = OP_TICK;
            if (r >= 60) ms = 8'($urandom_range(200, 255));
        end else if (r < 92) begin
            op  = OP_START;
            tgt = 2'($urandom_range(0, 2));
        end else if (r < 93) begin
            op = OP_ESTOP;
        end else if (r < 97) begin
            op = OP_START;
        end else begin
            op = OP_UNUSED;
        end
        send_beat(op, tgt, ms);
    endtask

    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        write_timings('0, '0, '0, '0);
        send_beat(OP_UNUSED, MODE_NONE, 8'hFF);
        send_beat(OP_TICK, MODE_AIR, 8'hFF);
        send_beat(OP_START, MODE_AIR, 8'h00);
        send_beat(OP_START, MODE_NONE, 8'h00);
        send_beat(OP_START, MODE_GROUND, 8'h00);
        send_beat(OP_START, MODE_SEA, 8'h00);
        send_beat(OP_TICK, MODE_NONE, 8'h00);
        send_beat(OP_TICK, MODE_AIR, 8'hFF);
        send_beat(OP_TICK, MODE_AIR, 8'h00);
        send_beat(OP_TICK, MODE_AIR, 8'h00);
        send_beat(OP_TICK, MODE_AIR, 8'h01);
        send_beat(OP_START, MODE_SEA, 8'h00);
        send_beat(OP_START, MODE_AIR, 8'h00);
        repeat (6) send_beat(OP_TICK, MODE_GROUND, 8'h80);
        send_beat(OP_START, MODE_SEA, 8'h7F);
        repeat (3) send_beat(OP_TICK, MODE_SEA, 8'h55);
        send_beat(OP_START, MODE_AIR, 8'hAA);
        send_beat(OP_ESTOP, MODE_NONE, 8'hFF);
        drain_results();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: write_timings('1, '1, '1, '1);
                1: write_timings(12'd1000, 12'd1000, 12'd1000, 8'd50);
                2: write_timings(12'd4000, 12'd4000, 12'd4000, 8'd200);
                default: write_timings(pick_duration(), pick_duration(), pick_duration(),
                                       pick_ramp_steps());
            endcase
            idle_on = (phase != NUM_PHASES - 1) && ($urandom_range(0, 4) != 0);
            repeat (PHASE_BEATS) random_beat();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS mode_transition_sequencer");
        end else begin
            $display("FAIL mode_transition_sequencer");
        end
        $finish;
    end

endmodule
